### hdl/nlt_pkg.sv
// nlt_pkg: shared types and constants of the neighbor link table.
// Used by nlt_ctrl, nlt_dpath and neighbor_link_table; no dependencies.
`default_nettype none
package nlt_pkg;
   localparam int unsigned DEF_ENTRIES = 8;
   localparam logic [15:0] DEF_TIMEOUT = 16'd60;
   localparam int unsigned MAX_REPORT = 8;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the request beat
      logic clr_i;       // i <= 0
      logic inc_i;       // i <= i + 1
      logic set_j;       // j <= (next i) + 1
      logic inc_j;       // j <= j + 1
      logic apply_rx;    // update found entry / insert / flag drop
      logic found_set;   // found <= i
      logic sweep_step;  // one step of the stale sweep at index i
      logic bump_send;   // add one to every send count
      logic swap_step;   // compare j against i, swap if stronger
   } nlt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_bcast;
      logic i_end;       // i >= count
      logic i_last;      // i + 1 >= count
      logic j_end;       // j >= count
      logic match;       // address at i equals sender
      logic stale;       // entry at i is older than the timeout
      logic rep_last;    // i + 1 == report length
   } nlt_sts_type;
endpackage
`default_nettype wire

### hdl/nlt_dpath.sv
// nlt_dpath: entry registers, index counters, compare and swap logic.
// Depends on nlt_pkg; driven by nlt_ctrl through nlt_cmd_type.
`default_nettype none
module nlt_dpath #(
   parameter int unsigned TABLE_ENTRIES = nlt_pkg::DEF_ENTRIES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire nlt_pkg::nlt_cmd_type cmd,
   output nlt_pkg::nlt_sts_type    sts,
   input  wire logic [15:0]        timeout,
   input  wire logic               in_action,
   input  wire logic [31:0]        in_now,
   input  wire logic [15:0]        in_addr,
   input  wire logic [15:0]        in_rssi,
   output logic [2:0]              o_rank,
   output logic [15:0]             o_addr,
   output logic [15:0]             o_rcv,
   output logic [15:0]             o_snd,
   output logic [15:0]             o_rssi,
   output logic                    o_drop
);
   import nlt_pkg::*;
   localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] FULL = IW'(TABLE_ENTRIES);
   localparam logic [IW-1:0] REPN = IW'((TABLE_ENTRIES < MAX_REPORT) ? TABLE_ENTRIES
                                                                    : MAX_REPORT);

   logic [15:0] addr_ff [TABLE_ENTRIES];
   logic [15:0] rcv_ff  [TABLE_ENTRIES];
   logic [15:0] snd_ff  [TABLE_ENTRIES];
   logic [15:0] rssi_ff [TABLE_ENTRIES];
   logic [31:0] time_ff [TABLE_ENTRIES];
   logic [IW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, found_ff, found_in;
   logic bcast_ff, drop_ff, drop_in;
   logic [31:0] now_ff;
   logic [15:0] a_ff, r_ff;
   logic [AW-1:0] ia, ja, fa;
   logic [IW-1:0] rep_n;
   logic [31:0] age;

   assign ia = i_ff[AW-1:0];
   assign ja = j_ff[AW-1:0];
   assign fa = found_ff[AW-1:0];
   assign rep_n = (cnt_ff < REPN) ? cnt_ff : REPN;
   assign age = now_ff - time_ff[ia];

   always_comb begin
      sts.is_bcast = bcast_ff;
      sts.i_end    = i_ff >= cnt_ff;
      sts.i_last   = (i_ff + IW'(1)) >= cnt_ff;
      sts.j_end    = j_ff >= cnt_ff;
      sts.match    = addr_ff[ia] == a_ff;
      sts.stale    = age > {16'd0, timeout};
      sts.rep_last = (i_ff + IW'(1)) == rep_n;
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      found_in = found_ff;
      cnt_in = cnt_ff;
      drop_in = drop_ff;
      if (cmd.load) drop_in = 1'b0;
      if (cmd.clr_i) i_in = '0;
      if (cmd.inc_i) i_in = i_ff + IW'(1);
      // j follows the index that i takes this cycle
      if (cmd.set_j) j_in = i_in + IW'(1);
      if (cmd.inc_j) j_in = j_ff + IW'(1);
      if (cmd.found_set) found_in = i_ff;
      if (cmd.load) found_in = cnt_ff;
      if (cmd.apply_rx && found_ff >= cnt_ff) begin
         if (cnt_ff < FULL) cnt_in = cnt_ff + IW'(1);
         else drop_in = 1'b1;
      end
      if (cmd.sweep_step && sts.stale) cnt_in = cnt_ff - IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         found_ff <= '0;
         drop_ff <= 1'b0;
         bcast_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         i_ff <= i_in;
         j_ff <= j_in;
         found_ff <= found_in;
         drop_ff <= drop_in;
         if (cmd.load) bcast_ff <= in_action;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= in_now;
         a_ff <= in_addr;
         r_ff <= in_rssi;
      end
      if (cmd.apply_rx) begin
         if (found_ff < cnt_ff) begin
            rcv_ff[fa] <= rcv_ff[fa] + 16'd1;
            rssi_ff[fa] <= r_ff;
            time_ff[fa] <= now_ff;
         end else if (cnt_ff < FULL) begin
            addr_ff[fa] <= a_ff;
            rcv_ff[fa] <= 16'd1;
            snd_ff[fa] <= 16'd1;
            rssi_ff[fa] <= r_ff;
            time_ff[fa] <= now_ff;
         end
      end
      // stale entry at i: shift everything above it down one place
      if (cmd.sweep_step && sts.stale) begin
         for (int k = 0; k + 1 < TABLE_ENTRIES; k++) begin
            if (IW'(k) >= i_ff) begin
               addr_ff[k] <= addr_ff[k+1];
               rcv_ff[k]  <= rcv_ff[k+1];
               snd_ff[k]  <= snd_ff[k+1];
               rssi_ff[k] <= rssi_ff[k+1];
               time_ff[k] <= time_ff[k+1];
            end
         end
      end
      if (cmd.bump_send) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) snd_ff[k] <= snd_ff[k] + 16'd1;
      end
      if (cmd.swap_step && $signed(rssi_ff[ja]) > $signed(rssi_ff[ia])) begin
         addr_ff[ia] <= addr_ff[ja];  addr_ff[ja] <= addr_ff[ia];
         rcv_ff[ia]  <= rcv_ff[ja];   rcv_ff[ja]  <= rcv_ff[ia];
         snd_ff[ia]  <= snd_ff[ja];   snd_ff[ja]  <= snd_ff[ia];
         rssi_ff[ia] <= rssi_ff[ja];  rssi_ff[ja] <= rssi_ff[ia];
         time_ff[ia] <= time_ff[ja];  time_ff[ja] <= time_ff[ia];
      end
   end

   assign o_rank = 3'(i_ff);
   assign o_addr = addr_ff[ia];
   assign o_rcv  = rcv_ff[ia];
   assign o_snd  = snd_ff[ia];
   assign o_rssi = rssi_ff[ia];
   assign o_drop = drop_ff;
endmodule
`default_nettype wire

### hdl/nlt_ctrl.sv
// nlt_ctrl: sequencer for lookup, update, sweep, sort and report.
// Depends on nlt_pkg; commands nlt_dpath and drives the output register load.
`default_nettype none
module nlt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   output logic                      req_ready,
   input  wire nlt_pkg::nlt_sts_type sts,
   output nlt_pkg::nlt_cmd_type      cmd,
   output logic                      emit,
   output logic                      emit_last,
   input  wire logic                 out_free
);
   import nlt_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_LOOK = 3'd1, S_APPLY = 3'd2,
                          S_SWEEP = 3'd3, S_SORT = 3'd4, S_RPT = 3'd5;
   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      emit = 1'b0;
      emit_last = 1'b0;
      req_ready = state_ff == S_IDLE;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd.load = 1'b1;
            cmd.clr_i = 1'b1;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (sts.is_bcast) begin
               state_in = S_SWEEP;
            end else if (sts.i_end) begin
               state_in = S_APPLY;
            end else if (sts.match) begin
               cmd.found_set = 1'b1;
               state_in = S_APPLY;
            end else cmd.inc_i = 1'b1;
         end
         S_APPLY: begin
            cmd.apply_rx = 1'b1;
            cmd.clr_i = 1'b1;
            cmd.set_j = 1'b1;
            state_in = S_SORT;
         end
         S_SWEEP: begin
            if (sts.i_end) begin
               cmd.bump_send = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.sweep_step = 1'b1;
               if (!sts.stale) cmd.inc_i = 1'b1;
            end
         end
         S_SORT: begin
            // j is i+1 here after APPLY (i=0)
            if (sts.i_last) begin
               cmd.clr_i = 1'b1;
               state_in = S_RPT;
            end else if (sts.j_end) begin
               // advance i and restart j right behind it
               cmd.inc_i = 1'b1;
               cmd.set_j = 1'b1;
            end else begin
               cmd.swap_step = 1'b1;
               cmd.inc_j = 1'b1;
            end
         end
         S_RPT: begin
            if (sts.i_end) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit = 1'b1;
               emit_last = sts.rep_last;
               cmd.inc_i = 1'b1;
               if (sts.rep_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### hdl/neighbor_link_table.sv
// neighbor_link_table: neighbor table with link statistics and RSSI ranking.
// Receive: accept, lookup, update, exchange sort, then report beats, one per cycle while
// the output can take them. Broadcast: sweep one entry per cycle plus send-count bump.
// One item at a time; output stalls lengthen the report phase beat for beat.
// Synchronous active-high reset empties the table and sets timeout to 60.
`default_nettype none
module neighbor_link_table #(
   parameter int unsigned TABLE_ENTRIES = nlt_pkg::DEF_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // now_seconds, sender_address, signal_strength
   input  wire logic        req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // rank, entry_address, received_count,
                                        // sent_count, entry_strength, dropped_full, pad
   output logic             rsp_tlast,  // last_entry
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import nlt_pkg::*;
   nlt_cmd_type cmd;
   nlt_sts_type sts;
   logic [15:0] tmo_ff;
   logic emit, emit_last, req_fire;
   logic [2:0] rk;
   logic [15:0] ad, rc, sc, rs;
   logic dr;
   logic [67:0] beat;

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) tmo_ff <= DEF_TIMEOUT;
      else if (csr_wr_en) tmo_ff <= csr_wr_data;
   end

   nlt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_ready(req_tready), .sts(sts), .cmd(cmd), .emit(emit),
      .emit_last(emit_last), .out_free(!rsp_tvalid || rsp_tready)
   );

   nlt_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .timeout(tmo_ff), .in_action(req_tuser), .in_now(req_tdata[31:0]),
      .in_addr(req_tdata[47:32]), .in_rssi(req_tdata[63:48]),
      .o_rank(rk), .o_addr(ad), .o_rcv(rc), .o_snd(sc), .o_rssi(rs), .o_drop(dr)
   );

   assign beat = {dr, rs, sc, rc, ad, rk};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (emit) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata <= {4'd0, beat};
         rsp_tlast <= emit_last;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> !req_tready) else $error("accept during report");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready) else $error("ready after load");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("beat lost");
endmodule
`default_nettype wire

### dv/neighbor_link_table_checker.sv
// neighbor_link_table_checker: watches the request, response and register ports,
// predicts the ranked neighbor report and compares every response beat.
// Depends on the neighbor_link_table port layout only.
`timescale 1ns / 100ps
`default_nettype none
module neighbor_link_table_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output int               error_count,
   output int               pending_count
);
   localparam int SLOTS = 8;
   localparam logic ACT_BROADCAST = 1'b1;

   typedef struct packed {
      logic [2:0]         rank;
      logic [15:0]        addr;
      logic [15:0]        rx_cnt;
      logic [15:0]        tx_cnt;
      logic signed [15:0] rssi;
      logic               dropped;
      logic               last;
   } report_beat_t;

   typedef struct packed {
      logic [15:0]        addr;
      logic [15:0]        rx_cnt;
      logic [15:0]        tx_cnt;
      logic signed [15:0] rssi;
      logic [31:0]        seen;
   } neighbor_t;

   neighbor_t     nbr [SLOTS];
   int            nbr_count;
   logic [15:0]   timeout_s;
   report_beat_t  expected_beats[$];

   assign pending_count = expected_beats.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic predict_report(input logic act, input logic [31:0] now,
                                 input logic [15:0] addr, input logic signed [15:0] rssi);
      int i, j, found;
      logic dropped;
      neighbor_t tmp;
      report_beat_t b;
      if (act == ACT_BROADCAST) begin
         i = 0;
         while (i < nbr_count) begin
            if (now - nbr[i].seen > {16'd0, timeout_s}) begin
               for (j = i; j + 1 < nbr_count; j++) nbr[j] = nbr[j + 1];
               nbr_count--;
            end else begin
               i++;
            end
         end
         for (i = 0; i < nbr_count; i++) nbr[i].tx_cnt++;
         return;
      end
      dropped = 1'b0;
      found = nbr_count;
      for (i = 0; i < nbr_count; i++)
         if (nbr[i].addr == addr && found == nbr_count) found = i;
      if (found < nbr_count) begin
         nbr[found].rx_cnt++;
         nbr[found].rssi = rssi;
         nbr[found].seen = now;
      end else if (nbr_count < SLOTS) begin
         nbr[nbr_count] = '{addr, 16'd1, 16'd1, rssi, now};
         nbr_count++;
      end else begin
         dropped = 1'b1;
      end
      // exchange sort: swap only when strictly stronger
      for (i = 0; i + 1 < nbr_count; i++)
         for (j = i + 1; j < nbr_count; j++)
            if ($signed(nbr[j].rssi) > $signed(nbr[i].rssi)) begin
               tmp = nbr[i]; nbr[i] = nbr[j]; nbr[j] = tmp;
            end
      for (i = 0; i < nbr_count; i++) begin
         b.rank = i[2:0];
         b.addr = nbr[i].addr;
         b.rx_cnt = nbr[i].rx_cnt;
         b.tx_cnt = nbr[i].tx_cnt;
         b.rssi = nbr[i].rssi;
         b.dropped = dropped;
         b.last = (i + 1 == nbr_count);
         expected_beats.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      report_beat_t w;
      if (reset) begin
         nbr_count = 0;
         timeout_s = 16'd60;
         expected_beats.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) timeout_s = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[31:0], 0);
            end else begin
               w = expected_beats.pop_front();
               if (rsp_tdata[2:0] != w.rank) report_mismatch("rank", rsp_tdata[2:0], w.rank);
               if (rsp_tdata[18:3] != w.addr)
                  report_mismatch("entry_address", rsp_tdata[18:3], w.addr);
               if (rsp_tdata[34:19] != w.rx_cnt)
                  report_mismatch("received_count", rsp_tdata[34:19], w.rx_cnt);
               if (rsp_tdata[50:35] != w.tx_cnt)
                  report_mismatch("sent_count", rsp_tdata[50:35], w.tx_cnt);
               if (rsp_tdata[66:51] != w.rssi)
                  report_mismatch("entry_strength", rsp_tdata[66:51], w.rssi);
               if (rsp_tdata[67] != w.dropped)
                  report_mismatch("dropped_full", rsp_tdata[67], w.dropped);
               if (rsp_tlast != w.last) report_mismatch("last_entry", rsp_tlast, w.last);
            end
         end
         if (req_tvalid && req_tready)
            predict_report(req_tuser, req_tdata[31:0], req_tdata[47:32], req_tdata[63:48]);
      end
   end
endmodule
`default_nettype wire

### dv/neighbor_link_table_test.sv
// neighbor_link_table_test: drives receive and broadcast beats and timeout writes
// into neighbor_link_table; neighbor_link_table_checker judges the responses.
// Depends on nlt_pkg, neighbor_link_table and neighbor_link_table_checker.
`timescale 1ns / 100ps
`default_nettype none
module neighbor_link_table_test;
   localparam logic ACT_RECEIVE = 1'b0;
   localparam logic ACT_BROADCAST = 1'b1;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   int          error_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;
   logic [31:0] clock_s = 32'd1000;
   logic [15:0] near_addr [12];

   neighbor_link_table dut (.*);

   neighbor_link_table_checker chk (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: own stall pattern, long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) rsp_tready <= 1'b0;
         else if ($urandom_range(0, 3) == 0) rsp_tready <= 1'($urandom_range(0, 1));
         else rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("neighbor_link_table test failed");
         $finish;
      end
   end

   task automatic send_beat(input logic act, input logic [31:0] now,
                            input logic [15:0] addr, input logic [15:0] rssi);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {rssi, addr, now};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_timeout(input logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // broadcasts leave nothing to wait on: give the block its own cycles
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int k;
      logic [15:0] a;
      for (k = 0; k < count; k++) begin
         clock_s = clock_s + $urandom_range(0, 40);
         if ($urandom_range(0, 19) == 0) clock_s = $urandom;
         a = $urandom_range(0, 4) == 0 ? 16'($urandom) : near_addr[$urandom_range(0, 11)];
         if ($urandom_range(0, 5) == 0)
            send_beat(ACT_BROADCAST, clock_s, 16'($urandom), 16'($urandom));
         else
            send_beat(ACT_RECEIVE, clock_s, a,
                      $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7)));
         pause_sender();
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < 12; k++) near_addr[k] = 16'($urandom);
      near_addr[0] = 16'h0000;
      near_addr[1] = 16'hFFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, fill past capacity, equal strengths, revisit
      send_beat(ACT_BROADCAST, 32'd0, 16'hFFFF, 16'hFFFF);
      send_beat(ACT_RECEIVE, 32'hFFFF_FFFF, 16'h0000, 16'h8000);
      send_beat(ACT_RECEIVE, 32'd0, 16'hFFFF, 16'h7FFF);
      for (k = 0; k < 8; k++)
         send_beat(ACT_RECEIVE, 32'd5, 16'h1000 + k[15:0], 16'(k % 3));
      send_beat(ACT_RECEIVE, 32'd6, 16'hFFFF, 16'h0000);
      send_beat(ACT_BROADCAST, 32'd10, 16'h0, 16'h0);
      send_beat(ACT_BROADCAST, 32'd80, 16'h0, 16'h0);
      send_beat(ACT_RECEIVE, 32'd81, 16'hAAAA, 16'h5555);
      send_beat(ACT_RECEIVE, 32'd81, 16'hAAAA, 16'hAAAA);

      write_timeout(16'd0);
      random_phase(50);
      write_timeout(16'hFFFF);
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off <= 1'b1;
            repeat (600) @(posedge clock);
            hold_off <= 1'b0;
         end
         begin
            random_phase(40);
            req_tvalid <= 1'b0;
         end
      join
      write_timeout(16'd30);
      random_phase(80);
      write_timeout(16'd60);
      random_phase(60);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("neighbor_link_table test passed");
      else
         $display("neighbor_link_table test failed");
      $finish;
   end
endmodule
`default_nettype wire
